// ----- src/drgl_pkg.sv -----
// shared types and constants for the receive log with duplicate grouping
package drgl_pkg;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK  = 1'b1;

  // configuration reset values
  localparam logic [15:0] WINDOW_RESET = 16'd5000;
  localparam logic [7:0]  CHUNK_RESET  = 8'd10;

  typedef struct packed {
    logic               command;
    logic               kind;
    logic [63:0]        key;
    logic signed [15:0] rssi_q;
    logic signed [15:0] snr_q;
    logic signed [31:0] freq_error;
    logic [31:0]        now_ms;
    logic               bad;
    logic [7:0]         read_index;
  } request_t;

  typedef struct packed {
    logic [7:0]         slot;
    logic [7:0]         count;
    logic               valid_res;
    logic               out_kind;
    logic [63:0]        out_key;
    logic signed [15:0] out_rssi_q;
    logic signed [15:0] out_snr_q;
    logic signed [31:0] out_freq_error;
    logic [31:0]        out_time_ms;
    logic               out_bad;
  } result_t;

  // one stored log entry
  typedef struct packed {
    logic               kind;
    logic               bad;
    logic [63:0]        key;
    logic signed [15:0] rssi_q;
    logic signed [15:0] snr_q;
    logic signed [31:0] freq_error;
    logic [31:0]        time_ms;
  } entry_t;

  typedef struct packed {
    logic [15:0] window;
    logic [7:0]  chunk;
  } cfg_t;

  // what every cell of the ring does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DOWN,
    CELL_UP,
    CELL_INSERT
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_SCAN,
    ST_PLACE,
    ST_READ
  } state_t;

endpackage

// ----- src/drgl_cell.sv -----
// one log entry cell of the ring, fed by both neighbors
module drgl_cell import drgl_pkg::*; #(
  parameter int CW  = 8,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  cell_op_t      op,
  input  logic [CW-1:0] lo,
  input  logic [CW-1:0] hi,
  input  entry_t        new_entry,
  input  entry_t        from_lo,
  input  entry_t        from_hi,
  output entry_t        entry
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  // hold, rotate either way, or open a gap for a new entry
  always_ff @(posedge clk) begin
    case (op)
      CELL_DOWN: entry <= from_hi;
      CELL_UP:   entry <= from_lo;
      CELL_INSERT: begin
        if (MY_IDX == lo) begin
          entry <= new_entry;
        end else if (MY_IDX > lo && MY_IDX <= hi) begin
          entry <= from_lo;
        end
      end
      default: entry <= entry;
    endcase
  end

endmodule

// ----- src/drgl_seq.sv -----
// sequencer: count, eviction, duplicate scan at the probe cell, reads and results
module drgl_seq import drgl_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int CW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  request_t      request,
  input  cfg_t          cfg,
  input  entry_t        probe,
  output logic          busy,
  output logic          done,
  output result_t       result,
  output cell_op_t      op,
  output logic [CW-1:0] lo,
  output logic [CW-1:0] hi,
  output entry_t        new_entry
);

  localparam int XW = CW + 8;
  localparam logic [CW-1:0] LAST = CW'(DEPTH - 1);

  state_t        state, state_next;
  request_t      item;
  logic [CW-1:0] cnt;
  logic [CW-1:0] jc;
  logic [CW-1:0] mpos;
  logic [7:0]    ec;
  logic          stopped;
  logic          matched;

  logic [7:0]    chunk_eff;
  logic          full;
  logic          drop_all;
  logic          read_ok;
  logic [31:0]   age;
  logic          probe_active;
  logic          probe_stale;
  logic          probe_hit;
  logic [CW:0]   mpos_inc;
  logic [CW-1:0] place_at;
  logic          cap_hit;

  // entry built from the item being inserted
  assign new_entry = '{kind: item.kind, bad: item.bad, key: item.key,
                       rssi_q: item.rssi_q, snr_q: item.snr_q,
                       freq_error: item.freq_error, time_ms: item.now_ms};

  // decisions on count, probe and placement
  always_comb begin
    chunk_eff    = (cfg.chunk == 8'd0) ? 8'd1 : cfg.chunk;
    full         = cnt >= LAST;
    drop_all     = XW'(chunk_eff) >= XW'(cnt);
    read_ok      = XW'(request.read_index) < XW'(cnt);
    age          = item.now_ms - probe.time_ms;
    probe_active = !stopped && (jc < cnt);
    probe_stale  = age > 32'(cfg.window);
    probe_hit    = (probe.kind == item.kind) && (probe.key == item.key);
    mpos_inc     = {1'b0, mpos} + 1'b1;
    place_at     = (matched && ({1'b0, cnt} > mpos_inc)) ? mpos_inc[CW-1:0] : cnt;
    cap_hit      = XW'(jc) == XW'(item.read_index);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (request.command == CMD_READ) begin
            state_next = read_ok ? ST_READ : ST_IDLE;
          end else if (full) begin
            state_next = drop_all ? ST_PLACE : ST_EVICT;
          end else if (request.bad || cnt == '0) begin
            state_next = ST_PLACE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_EVICT: begin
        if (ec == 8'd1) begin
          state_next = item.bad ? ST_PLACE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (jc == '0) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: state_next = ST_IDLE;
      ST_READ: begin
        if (jc == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ring control
  always_comb begin
    busy = state != ST_IDLE;
    lo   = place_at;
    hi   = cnt;
    case (state)
      ST_EVICT: op = CELL_DOWN;
      ST_SCAN:  op = CELL_UP;
      ST_READ:  op = CELL_UP;
      ST_PLACE: op = CELL_INSERT;
      default:  op = CELL_HOLD;
    endcase
  end

  // state, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      jc      <= LAST;
      stopped <= 1'b0;
      matched <= 1'b0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      // result strobe at the end of every item
      done  <= (state == ST_PLACE) || (state == ST_READ && jc == '0) ||
               (state == ST_IDLE && start && request.command == CMD_READ && !read_ok);
      case (state)
        ST_IDLE: begin
          stopped <= 1'b0;
          matched <= 1'b0;
          jc      <= LAST;
          if (start) begin
            item <= request;
            if (request.command == CMD_READ) begin
              if (!read_ok) begin
                result <= '{slot: request.read_index, count: 8'(cnt), valid_res: 1'b0,
                            out_kind: 1'b0, out_key: '0,
                            out_rssi_q: '0, out_snr_q: '0,
                            out_freq_error: '0, out_time_ms: '0,
                            out_bad: 1'b0};
              end
            end else if (full) begin
              if (drop_all) begin
                cnt <= '0;
              end else begin
                cnt <= cnt - CW'(chunk_eff);
              end
              ec <= chunk_eff;
            end
          end
        end
        ST_EVICT: ec <= ec - 8'd1;
        ST_SCAN: begin
          jc <= jc - 1'b1;
          if (probe_active) begin
            if (probe_stale) begin
              stopped <= 1'b1;
            end else if (probe_hit) begin
              stopped <= 1'b1;
              matched <= 1'b1;
              mpos    <= jc;
            end
          end
        end
        ST_PLACE: begin
          cnt  <= cnt + 1'b1;
          result <= '{slot: 8'(place_at), count: 8'(cnt + 1'b1), valid_res: 1'b1,
                      out_kind: item.kind, out_key: item.key,
                      out_rssi_q: item.rssi_q, out_snr_q: item.snr_q,
                      out_freq_error: item.freq_error, out_time_ms: item.now_ms,
                      out_bad: item.bad};
        end
        ST_READ: begin
          jc <= jc - 1'b1;
          if (cap_hit) begin
            result <= '{slot: item.read_index, count: 8'(cnt), valid_res: 1'b1,
                        out_kind: probe.kind, out_key: probe.key,
                        out_rssi_q: probe.rssi_q, out_snr_q: probe.snr_q,
                        out_freq_error: probe.freq_error, out_time_ms: probe.time_ms,
                        out_bad: probe.bad};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- src/dedup_grouping_receive_log_unit.sv -----
// top level: configuration registers, ring of entry cells and sequencer
//
// Ordered receive log of up to DEPTH-1 entries kept in a ring of cells; a
// duplicate scan or a valid read walks the ring by rotation, with one probe
// cell at the top end. A read at or past the count gives its result in the
// next cycle. An insert runs the full duplicate scan (one ring rotation),
// after evicting entries when the log is full; a bad packet or an empty log
// skips the scan, and dropping the whole log needs no eviction and skips the
// scan. busy is high while an item is in work, and the result strobe done
// comes in the cycle busy drops (next cycle for an invalid read). Results
// cannot be held off. Cell contents have no reset; only the count, the
// configuration registers and the control logic are cleared.
module dedup_grouping_receive_log_unit import drgl_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  request_t              request,
  output logic                  busy,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(DEPTH);

  cfg_t          cfg;
  cell_op_t      op;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  entry_t        new_entry;
  entry_t        cells [DEPTH];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window <= WINDOW_RESET;
      cfg.chunk  <= CHUNK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW: cfg.window <= cfg_data;
        REG_CHUNK:  cfg.chunk  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ring of entry cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam int LO_N = (k == 0) ? DEPTH - 1 : k - 1;
    localparam int HI_N = (k == DEPTH - 1) ? 0 : k + 1;
    drgl_cell #(
      .CW  (CW),
      .IDX (k)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .lo        (lo),
      .hi        (hi),
      .new_entry (new_entry),
      .from_lo   (cells[LO_N]),
      .from_hi   (cells[HI_N]),
      .entry     (cells[k])
    );
  end

  // sequencer, probing the top cell of the ring
  drgl_seq #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .cfg       (cfg),
    .probe     (cells[DEPTH-1]),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .op        (op),
    .lo        (lo),
    .hi        (hi),
    .new_entry (new_entry)
  );

`ifndef ASSERT_OFF
  // an insert started while idle always raises busy
  a_insert_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command == CMD_INSERT) |=> busy)
    else $error("insert did not raise busy");

  // finishing an item always delivers its result
  a_done_at_end: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy dropped without a result");

  // an invalid read gives cleared entry fields
  a_invalid_clear: assert property (@(posedge clk) disable iff (rst)
    (done && !result.valid_res) |-> (result.out_key == '0 && result.out_time_ms == '0))
    else $error("invalid read returned entry data");
`endif

endmodule
